/* src/kff_pkg.sv */
// ----------------------------------------------------------------------------
// kff_pkg
// Shared types, constants and helpers for the scalar-observation Kalman filter.
// ----------------------------------------------------------------------------
package kff_pkg;

  localparam int DIV_W = 64;   // divider dividend / quotient width
  localparam int DVS_W = 31;   // divider divisor width
  localparam int NV_W  = 31;   // observation noise register width

  // ln 2 in Q1.31 (ln 2 * 2^32 is even, so halving it is exact)
  localparam logic signed [31:0] LN2_Q31    = 32'sd1488522236;
  localparam logic signed [63:0] LN_2PI_Q32 = 64'sd7893621894;
  localparam logic [NV_W-1:0]    NV_RESET   = 31'd65536;

  typedef enum logic [2:0] {
    MODE_PHI   = 3'd0,
    MODE_QN    = 3'd1,
    MODE_PRIOR = 3'd2,
    MODE_START = 3'd3,
    MODE_STEP  = 3'd4
  } mode_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

/* src/kff_div.sv */
// ----------------------------------------------------------------------------
// kff_div
// Restoring unsigned divider, one quotient bit per cycle, registered result.
// ----------------------------------------------------------------------------
module kff_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [kff_pkg::DIV_W-1:0]   dividend,
  input  logic [kff_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [kff_pkg::DIV_W-1:0]   quotient
);
  import kff_pkg::*;

  localparam int CW = $clog2(DIV_W);
  localparam logic [CW-1:0] CNT_LAST = CW'(DIV_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DIV_W-1:0] quo_r;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvs_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], fits};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* src/kalman_forward_filter_scalar_obs.sv */
// ----------------------------------------------------------------------------
// kalman_forward_filter_scalar_obs
// Forward Kalman filter with a noisy scalar observation of state element 0.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): load items write one element of the
// transition, process-noise or prior matrix. A start item restarts from the
// prior, a step item predicts; either one optionally absorbs an observation
// and then returns STATE_DIM results on the out_ channel, one per state
// element, out_last on the final one.
// An unobserved step runs a multiply and an accumulate state per product term
// through the one shared 32x32 multiplier and a store state per matrix element.
// An observed step is dominated by the bit-serial divider, used once per gain
// element and once for the squared innovation, plus up to 30 normalising
// shifts and the log squaring on the same multiplier. in_stall is high while
// a start or step item is processed.
// The result sits in an output register; while the receiver holds out_stall
// the sequencer waits, and after the last result is loaded a new item can
// be taken. Reset clears the state mean, covariance, running sum and sets the
// noise variance to 1.0; matrices must be loaded before use.
// ----------------------------------------------------------------------------
module kalman_forward_filter_scalar_obs #(
  parameter int STATE_DIM = 2,
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_mode,
  input  logic [1:0]                in_row,
  input  logic [1:0]                in_col,
  input  logic signed [31:0]        in_value,
  input  logic                      in_observed,
  input  logic signed [31:0]        in_observation,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_state_index,
  output logic signed [31:0]        out_mean_element,
  output logic signed [31:0]        out_variance_element,
  output logic signed [31:0]        out_running_nll,
  output logic                      out_last,
  input  logic                      cfg_wr_en,
  input  logic [kff_pkg::NV_W-1:0]  cfg_wr_data
);
  import kff_pkg::*;

  localparam int NSQ = STATE_DIM * STATE_DIM;
  localparam int NW  = (NSQ > 1) ? $clog2(NSQ) : 1;
  localparam int DI  = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
  localparam logic [1:0] DL = 2'(STATE_DIM - 1);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] LN2PI_F =
    (LN_2PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  localparam logic [4:0] SQ_LAST = 5'(FRAC_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_ACC, S_STORE, S_KEEP, S_OBS, S_DIVG, S_WAITG, S_EE,
    S_DIVE, S_WAITE, S_NORM, S_SQ, S_SQA, S_LNM, S_LNA, S_NLL, S_OUT
  } state_t;

  typedef enum logic [2:0] {PH_PM, PH_PZ, PH_PP, PH_MEAN, PH_COV} phase_t;

  function automatic logic [NW-1:0] ix(input logic [1:0] r, input logic [1:0] c);
    ix = NW'(32'(r) * 32'(STATE_DIM) + 32'(c));
  endfunction

  state_t state_r;
  phase_t phase_r;

  logic signed [31:0] phi_r  [NSQ];
  logic signed [31:0] qn_r   [NSQ];
  logic signed [31:0] pri_r  [NSQ];
  logic signed [31:0] v_r    [NSQ];
  logic signed [31:0] p_r    [NSQ];
  logic signed [31:0] z_r    [NSQ];
  logic signed [31:0] m_r    [STATE_DIM];
  logic signed [31:0] pred_r [STATE_DIM];
  logic signed [31:0] gain_r [STATE_DIM];

  logic signed [31:0] nll_r, e_r, y_r;
  logic [NV_W-1:0]    nv_r;
  logic [30:0]        pv_r;
  logic               obs_r, neg_r;
  logic signed [63:0] acc_r, mul_r, t_r;
  logic [1:0]         i_r, j_r, k_r;
  logic [30:0]        lm_r;
  logic [4:0]         msb_r, sq_r;
  logic [FRAC_BITS-1:0] frac_r;

  logic               out_valid_r, out_last_r;
  logic [1:0]         out_idx_r;
  logic signed [31:0] out_mean_r, out_var_r, out_nll_r;

  // datapath signals
  logic [NW-1:0]      phi_addr, p_addr, v_addr;
  logic [1:0]         m_idx;
  logic signed [31:0] phi_rd, p_rd, v_rd, m_rd;
  logic signed [31:0] sel_a, sel_b, base, lq, acc_v, gval, pvs;
  logic signed [63:0] rnd, acc_sum, p_abs, gq, ln;
  logic [1:0]         klast, jlast;
  logic [32:0]        t2;
  logic [30:0]        pv_c;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dividend, div_q;
  logic               in_range;

  assign in_stall = (state_r != S_IDLE);
  assign in_range = ({1'b0, in_row} < 3'(STATE_DIM)) && ({1'b0, in_col} < 3'(STATE_DIM));

  // one read address per array per cycle
  assign phi_addr = (phase_r == PH_PP) ? ix(j_r, k_r) : ix(i_r, k_r);
  assign v_addr   = (state_r == S_OUT) ? ix(i_r, i_r) : ix(k_r, j_r);
  assign m_idx    = (state_r == S_OUT) ? i_r : k_r;

  always_comb begin
    priority if (state_r == S_OBS) begin
      p_addr = ix(2'd0, 2'd0);
    end else if (state_r == S_MUL) begin
      p_addr = ix(2'd0, j_r);
    end else if (state_r == S_DIVG) begin
      p_addr = ix(i_r, 2'd0);
    end else begin
      p_addr = ix(i_r, j_r);
    end
  end

  assign phi_rd = phi_r[phi_addr];
  assign p_rd   = p_r[p_addr];
  assign v_rd   = v_r[v_addr];
  assign m_rd   = m_r[m_idx[DI-1:0]];

  assign lq = ((32'(msb_r) - 32'(FRAC_BITS)) << FRAC_BITS) + 32'(frac_r);

  always_comb begin
    sel_a = '0;
    sel_b = '0;
    unique case (state_r)
      S_MUL: begin
        unique case (phase_r)
          PH_PM:   begin sel_a = phi_rd;                 sel_b = m_rd;   end
          PH_PZ:   begin sel_a = phi_rd;                 sel_b = v_rd;   end
          PH_PP:   begin sel_a = z_r[ix(i_r, k_r)];      sel_b = phi_rd; end
          PH_MEAN: begin sel_a = gain_r[i_r[DI-1:0]];    sel_b = e_r;    end
          PH_COV:  begin sel_a = gain_r[i_r[DI-1:0]];    sel_b = p_rd;   end
          default: ;
        endcase
      end
      S_EE:  begin sel_a = e_r;            sel_b = e_r;            end
      S_SQ:  begin sel_a = {1'b0, lm_r};   sel_b = {1'b0, lm_r};   end
      S_LNM: begin sel_a = lq;             sel_b = LN2_Q31;        end
      default: ;
    endcase
  end

  always_comb begin
    unique case (phase_r)
      PH_PP:   base = qn_r[ix(i_r, j_r)];
      PH_MEAN: base = pred_r[i_r[DI-1:0]];
      PH_COV:  base = p_rd;
      default: base = '0;
    endcase
  end

  assign klast = ((phase_r == PH_MEAN) || (phase_r == PH_COV)) ? 2'd0 : DL;
  assign jlast = ((phase_r == PH_PM) || (phase_r == PH_MEAN)) ? 2'd0 : DL;

  assign rnd = (mul_r + HALF) >>> FRAC_BITS;
  always_comb begin
    if (k_r != 2'd0) begin
      acc_sum = acc_r + rnd;
    end else if (phase_r == PH_COV) begin
      acc_sum = 64'(base) - rnd;
    end else begin
      acc_sum = 64'(base) + rnd;
    end
  end
  assign acc_v = sat32(acc_r);

  // innovation variance, floored at one LSB
  assign pvs  = sat32(64'(p_rd) + 64'(nv_r));
  assign pv_c = (pvs < 32'sd1) ? 31'd1 : pvs[30:0];

  assign p_abs        = p_rd[31] ? -64'(p_rd) : 64'(p_rd);
  assign div_start    = (state_r == S_DIVG) || (state_r == S_DIVE);
  assign div_dividend = (state_r == S_DIVG) ? DIV_W'(p_abs <<< FRAC_BITS) : DIV_W'(mul_r);
  assign gq           = $signed(div_q);
  assign gval         = sat32(neg_r ? -gq : gq);
  assign t2           = mul_r[62:30];
  assign ln           = (mul_r + 64'sd1073741824) >>> 31;

  kff_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (pv_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    mul_r <= sel_a * sel_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_PM;
      out_valid_r <= 1'b0;
      nv_r        <= NV_RESET;
      nll_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      for (int d = 0; d < STATE_DIM; d++) m_r[d] <= '0;
      for (int n = 0; n < NSQ; n++) v_r[n] <= '0;
    end else begin
      if (cfg_wr_en) nv_r <= cfg_wr_data;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            obs_r <= in_observed;
            y_r   <= in_observation;
            i_r   <= '0;
            j_r   <= '0;
            k_r   <= '0;
            unique case (in_mode)
              MODE_PHI:   if (in_range) phi_r[ix(in_row, in_col)] <= in_value;
              MODE_QN:    if (in_range) qn_r[ix(in_row, in_col)]  <= in_value;
              MODE_PRIOR: if (in_range) pri_r[ix(in_row, in_col)] <= in_value;
              MODE_START: begin
                for (int d = 0; d < STATE_DIM; d++) pred_r[d] <= '0;
                for (int n = 0; n < NSQ; n++) p_r[n] <= pri_r[n];
                nll_r   <= '0;
                state_r <= in_observed ? S_OBS : S_KEEP;
              end
              MODE_STEP: begin
                phase_r <= PH_PM;
                state_r <= S_MUL;
              end
              default: ;
            endcase
          end
        end
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          acc_r <= acc_sum;
          if (k_r == klast) begin
            state_r <= S_STORE;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_MUL;
          end
        end
        S_STORE: begin
          unique case (phase_r)
            PH_PM:   pred_r[i_r[DI-1:0]] <= acc_v;
            PH_PZ:   z_r[ix(i_r, j_r)]   <= acc_v;
            PH_PP:   p_r[ix(i_r, j_r)]   <= acc_v;
            PH_MEAN: m_r[i_r[DI-1:0]]    <= acc_v;
            PH_COV:  v_r[ix(i_r, j_r)]   <= acc_v;
            default: ;
          endcase
          k_r     <= '0;
          state_r <= S_MUL;
          if (j_r == jlast) begin
            j_r <= '0;
            if (i_r == DL) begin
              i_r <= '0;
              unique case (phase_r)
                PH_PM:   phase_r <= PH_PZ;
                PH_PZ:   phase_r <= PH_PP;
                PH_PP:   state_r <= obs_r ? S_OBS : S_KEEP;
                PH_MEAN: phase_r <= PH_COV;
                PH_COV:  state_r <= S_EE;
                default: ;
              endcase
            end else begin
              i_r <= i_r + 2'd1;
            end
          end else begin
            j_r <= j_r + 2'd1;
          end
        end
        S_KEEP: begin
          for (int d = 0; d < STATE_DIM; d++) m_r[d] <= pred_r[d];
          for (int n = 0; n < NSQ; n++) v_r[n] <= p_r[n];
          i_r     <= '0;
          state_r <= S_OUT;
        end
        S_OBS: begin
          pv_r    <= pv_c;
          e_r     <= sat32(64'(y_r) - 64'(pred_r[0]));
          i_r     <= '0;
          state_r <= S_DIVG;
        end
        S_DIVG: begin
          neg_r   <= p_rd[31];
          state_r <= S_WAITG;
        end
        S_WAITG: begin
          if (div_done) begin
            gain_r[i_r[DI-1:0]] <= gval;
            if (i_r == DL) begin
              i_r     <= '0;
              j_r     <= '0;
              k_r     <= '0;
              phase_r <= PH_MEAN;
              state_r <= S_MUL;
            end else begin
              i_r     <= i_r + 2'd1;
              state_r <= S_DIVG;
            end
          end
        end
        S_EE:   state_r <= S_DIVE;
        S_DIVE: state_r <= S_WAITE;
        S_WAITE: begin
          if (div_done) begin
            t_r     <= LN2PI_F + gq;
            lm_r    <= pv_r;
            msb_r   <= 5'd30;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // bring the leading one of pv up to bit 30
          if (lm_r[30]) begin
            sq_r    <= '0;
            frac_r  <= '0;
            state_r <= S_SQ;
          end else begin
            lm_r  <= lm_r << 1;
            msb_r <= msb_r - 5'd1;
          end
        end
        S_SQ: state_r <= S_SQA;
        S_SQA: begin
          if (t2[31]) begin
            lm_r   <= t2[31:1];
            frac_r <= {frac_r[FRAC_BITS-2:0], 1'b1};
          end else begin
            lm_r   <= t2[30:0];
            frac_r <= {frac_r[FRAC_BITS-2:0], 1'b0};
          end
          if (sq_r == SQ_LAST) begin
            state_r <= S_LNM;
          end else begin
            sq_r    <= sq_r + 5'd1;
            state_r <= S_SQ;
          end
        end
        S_LNM: state_r <= S_LNA;
        S_LNA: begin
          t_r     <= t_r + ln;
          state_r <= S_NLL;
        end
        S_NLL: begin
          nll_r   <= sat32(64'(nll_r) + ((t_r + 64'sd1) >>> 1));
          i_r     <= '0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= i_r;
            out_mean_r  <= m_rd;
            out_var_r   <= v_rd;
            out_nll_r   <= nll_r;
            out_last_r  <= (i_r == DL);
            if (i_r == DL) begin
              i_r     <= '0;
              state_r <= S_IDLE;
            end else begin
              i_r <= i_r + 2'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_state_index      = out_idx_r;
  assign out_mean_element     = out_mean_r;
  assign out_variance_element = out_var_r;
  assign out_running_nll      = out_nll_r;
  assign out_last             = out_last_r;

  // divider only finishes while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_WAITG || state_r == S_WAITE))
    else $error("divider finished outside a wait state");

  // a step transfer starts the mean prediction
  a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_mode == MODE_STEP) |=> (state_r == S_MUL && phase_r == PH_PM))
    else $error("step transfer did not start prediction");

  // divisor is never zero when a gain or squared-innovation division starts
  a_pv_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVG || state_r == S_DIVE) |-> (pv_r != 31'd0))
    else $error("zero innovation variance at divider start");

  // last flag marks the final state element
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_state_index == DL))
    else $error("last flag on wrong state element");

endmodule

/* tb/sv/kff_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kff_checker
// Watches the item, result and register ports of the Kalman filter, keeps its
// own fixed-point copy of the filter state and checks every result transfer.
// ----------------------------------------------------------------------------
module kff_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [2:0]                in_mode,
  input  logic [1:0]                in_row,
  input  logic [1:0]                in_col,
  input  logic signed [31:0]        in_value,
  input  logic                      in_observed,
  input  logic signed [31:0]        in_observation,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [1:0]                out_state_index,
  input  logic signed [31:0]        out_mean_element,
  input  logic signed [31:0]        out_variance_element,
  input  logic signed [31:0]        out_running_nll,
  input  logic                      out_last,
  input  logic                      cfg_wr_en,
  input  logic [kff_pkg::NV_W-1:0]  cfg_wr_data,
  output int                        pending,
  output int                        fail_count,
  output int                        result_count
);
  import kff_pkg::*;

  localparam int  N      = 2;
  localparam int  FB     = 16;
  localparam longint LN2_K = 64'sd2977044472;

  typedef struct {
    logic [1:0]         idx;
    logic signed [31:0] mean;
    logic signed [31:0] var_d;
    logic signed [31:0] nll;
    logic               last;
  } filt_out_t;

  filt_out_t exp_q[$];

  int phi_m [N*N];
  int qn_m  [N*N];
  int pri_m [N*N];
  int x_est [N];
  int v_est [N*N];
  int nll_acc;
  longint nv_reg;

  function automatic longint rnd_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint mulq(int a, int b);
    return rnd_shr(longint'(a) * longint'(b), FB);
  endfunction

  function automatic longint ln_q(int x);
    int msb;
    longint unsigned m;
    longint frac;
    longint l2;
    msb = 0;
    frac = 0;
    for (int i = 0; i < 31; i++) if (x[i]) msb = i;
    m = {32'b0, x} << (30 - msb);
    for (int i = 0; i < FB; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'd2147483648) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    l2 = longint'(msb - FB) * 65536 + frac;
    return rnd_shr(l2 * LN2_K, 32);
  endfunction

  task automatic run_filter(logic [2:0] md, logic [1:0] r, logic [1:0] c, int val,
                            logic obs, int y);
    int pred [N];
    int pp [N*N];
    int zz [N*N];
    int gn [N];
    longint s, pv, term;
    int e;
    filt_out_t o;
    if (md <= MODE_PRIOR) begin
      if (r < N && c < N) begin
        case (md)
          MODE_PHI: phi_m[r*N+c] = val;
          MODE_QN:  qn_m[r*N+c]  = val;
          default:  pri_m[r*N+c] = val;
        endcase
      end
      return;
    end
    if (md > MODE_STEP) return;
    if (md == MODE_START) begin
      for (int i = 0; i < N; i++) pred[i] = 0;
      for (int i = 0; i < N*N; i++) pp[i] = pri_m[i];
      nll_acc = 0;
    end else begin
      for (int i = 0; i < N; i++) begin
        s = 0;
        for (int j = 0; j < N; j++) s += mulq(phi_m[i*N+j], x_est[j]);
        pred[i] = clamp32(s);
      end
      for (int i = 0; i < N; i++)
        for (int j = 0; j < N; j++) begin
          s = 0;
          for (int k = 0; k < N; k++) s += mulq(phi_m[i*N+k], v_est[k*N+j]);
          zz[i*N+j] = clamp32(s);
        end
      for (int i = 0; i < N; i++)
        for (int j = 0; j < N; j++) begin
          s = qn_m[i*N+j];
          for (int k = 0; k < N; k++) s += mulq(zz[i*N+k], phi_m[j*N+k]);
          pp[i*N+j] = clamp32(s);
        end
    end
    if (obs) begin
      pv = clamp32(longint'(pp[0]) + nv_reg);
      if (pv < 1) pv = 1;  // non-positive innovation variance
      e = clamp32(longint'(y) - longint'(pred[0]));
      for (int i = 0; i < N; i++) gn[i] = clamp32((longint'(pp[i*N]) * 65536) / pv);
      for (int i = 0; i < N; i++) x_est[i] = clamp32(longint'(pred[i]) + mulq(gn[i], e));
      for (int i = 0; i < N; i++)
        for (int j = 0; j < N; j++)
          v_est[i*N+j] = clamp32(longint'(pp[i*N+j]) - mulq(gn[i], pp[j]));
      term = rnd_shr(LN_2PI_Q32, 32 - FB);
      term += ln_q(int'(pv));
      term += (longint'(e) * longint'(e)) / pv;
      term = rnd_shr(term, 1);
      nll_acc = clamp32(longint'(nll_acc) + term);
    end else begin
      for (int i = 0; i < N; i++) x_est[i] = pred[i];
      for (int i = 0; i < N*N; i++) v_est[i] = pp[i];
    end
    for (int i = 0; i < N; i++) begin
      o.idx   = 2'(i);
      o.mean  = x_est[i];
      o.var_d = v_est[i*N+i];
      o.nll   = nll_acc;
      o.last  = (i == N - 1);
      exp_q.push_back(o);
    end
  endtask

  always @(posedge clk) begin
    filt_out_t w;
    if (!rst_n) begin
      for (int i = 0; i < N*N; i++) begin
        phi_m[i] = 0; qn_m[i] = 0; pri_m[i] = 0; v_est[i] = 0;
      end
      for (int i = 0; i < N; i++) x_est[i] = 0;
      nll_acc = 0;
      nv_reg = NV_RESET;
      exp_q.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (cfg_wr_en) nv_reg = cfg_wr_data;
      if (out_valid && !out_stall) begin
        result_count++;
        if (exp_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          w = exp_q.pop_front();
          if (out_state_index !== w.idx) begin
            $error("state_index exp %0d got %0d", w.idx, out_state_index);
            fail_count++;
          end
          if (out_mean_element !== w.mean) begin
            $error("mean_element exp %0d got %0d", w.mean, out_mean_element);
            fail_count++;
          end
          if (out_variance_element !== w.var_d) begin
            $error("variance_element exp %0d got %0d", w.var_d, out_variance_element);
            fail_count++;
          end
          if (out_running_nll !== w.nll) begin
            $error("running_nll exp %0d got %0d", w.nll, out_running_nll);
            fail_count++;
          end
          if (out_last !== w.last) begin
            $error("last exp %0d got %0d", w.last, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        run_filter(in_mode, in_row, in_col, in_value, in_observed, in_observation);
    end
    pending = exp_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the scalar-observation Kalman filter: directed
// loads, starts and steps, then random sequences under four idling phases.
// ----------------------------------------------------------------------------
module tb_top;
  import kff_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_mode = '0;
  logic [1:0] in_row = '0;
  logic [1:0] in_col = '0;
  logic signed [31:0] in_value = '0;
  logic in_observed = 1'b0;
  logic signed [31:0] in_observation = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_state_index;
  logic signed [31:0] out_mean_element, out_variance_element, out_running_nll;
  logic out_last;
  logic cfg_wr_en = 1'b0;
  logic [NV_W-1:0] cfg_wr_data = '0;

  int pending, fail_count, result_count;
  int tx_pct = 0, rx_pct = 0;
  int n_items = 0;
  int cycles = 0;
  int hold_cnt = 0;
  logic hold_start = 1'b0, hold_taken = 1'b0;

  kalman_forward_filter_scalar_obs u_top (.*);

  kff_checker u_chk (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall, plus one long hold-off counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_start && !hold_taken) begin
      out_stall <= 1'b1;
      hold_cnt <= 1500;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  task automatic send(logic [2:0] md, logic [1:0] r, logic [1:0] c, logic [31:0] val,
                      logic obs, logic [31:0] y);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_mode <= md; in_row <= r; in_col <= c; in_value <= val;
    in_observed <= obs; in_observation <= y;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    n_items++;
  endtask

  // one edge first so the checker has booked the last transfer
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_nv(logic [NV_W-1:0] d);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // value near unity, occasionally any bit pattern
  function automatic logic [31:0] mild(int span);
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(2 * span) - span;
  endfunction

  task automatic random_burst(int count);
    int pick;
    logic [2:0] md;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        md = 3'($urandom_range(2));
        send(md, 2'($urandom_range(1)), 2'($urandom_range(1)),
             (md == MODE_PHI) ? mild(70000) : mild(40000), 1'($urandom), $urandom);
      end else if (pick < 15) begin
        // ignored items: spare modes or loads outside the matrix
        if ($urandom_range(1)) send(3'($urandom_range(7, 5)), 2'($urandom), 2'($urandom),
                                    $urandom, 1'($urandom), $urandom);
        else send(3'($urandom_range(2)), 2'(2 + $urandom_range(1)), 2'($urandom),
                  $urandom, 1'($urandom), $urandom);
      end else if (pick < 25) begin
        send(MODE_START, 2'($urandom), 2'($urandom), $urandom, ($urandom_range(9) < 7),
             mild(300000));
      end else begin
        send(MODE_STEP, 2'($urandom), 2'($urandom), $urandom, ($urandom_range(9) < 7),
             mild(300000));
      end
    end
  endtask

  task automatic load_all(int p0, int p1, int p2, int p3);
    send(MODE_PHI, 0, 0, p0, 0, 0);
    send(MODE_PHI, 0, 1, p1, 0, 0);
    send(MODE_PHI, 1, 0, p2, 0, 0);
    send(MODE_PHI, 1, 1, p3, 0, 0);
    send(MODE_QN, 0, 0, 32'sd3277, 0, 0);
    send(MODE_QN, 0, 1, 0, 0, 0);
    send(MODE_QN, 1, 0, 0, 0, 0);
    send(MODE_QN, 1, 1, 32'sd6554, 0, 0);
    send(MODE_PRIOR, 0, 0, 32'sd65536, 0, 0);
    send(MODE_PRIOR, 0, 1, 32'sd16384, 0, 0);
    send(MODE_PRIOR, 1, 0, 32'sd16384, 0, 0);
    send(MODE_PRIOR, 1, 1, 32'sd131072, 0, 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_nv(NV_RESET);

    // directed part
    send(MODE_PHI, 3, 2, 32'h80000000, 1, 32'h7fffffff);  // outside matrix: ignored
    send(3'd5, 0, 0, 32'h7fffffff, 1, 0);
    send(3'd7, 3, 3, 32'hffffffff, 1, 32'hffffffff);
    load_all(32'sd65536, 32'sd6554, 32'sh7fffffff, 32'sd58982);
    send(MODE_PHI, 1, 0, 0, 0, 0);
    send(MODE_START, 0, 0, 0, 0, 0);
    send(MODE_START, 0, 0, 0, 1, 32'sh7fffffff);
    send(MODE_STEP, 0, 0, 0, 1, 32'sh80000000);
    send(MODE_STEP, 0, 0, 0, 0, 0);
    send(MODE_PRIOR, 0, 0, 32'sh80000000, 0, 0);        // negative innovation variance
    send(MODE_START, 0, 0, 0, 1, 32'sd65536);
    send(MODE_PRIOR, 0, 0, 32'sd65536, 0, 0);
    send(MODE_STEP, 0, 0, 0, 1, 32'sd20000);

    // phase 1: no idling
    drain();
    write_nv(31'h7fffffff);
    random_burst(52);

    // phase 2: sender idle, long receiver hold-off while items keep coming
    drain();
    write_nv(31'd0);
    tx_pct = 64;
    hold_start = 1'b1;
    random_burst(52);

    // phase 3: receiver stalling
    drain();
    write_nv(NV_W'($urandom_range(1 << 20, 1 << 12)));
    tx_pct = 0;
    rx_pct = 64;
    random_burst(52);

    // phase 4: both idle
    drain();
    write_nv(31'd65536);
    tx_pct = 24;
    rx_pct = 24;
    random_burst(52);

    drain();
    $display("Sent %0d items (loads, starts, observed and unobserved steps, ignored items)",
             n_items);
    $display("Checked %0d result transfers over four noise settings and idling phases",
             result_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
